FILE: src/sidiv_pkg.sv
// ----------------------------------------------------------------------------
// sidiv_pkg
// Shared widths for the signed integer divider.
// ----------------------------------------------------------------------------
package sidiv_pkg;

	// operand and quotient width
	localparam int DATA_WIDTH = 32;

	// stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 2;

	// bit positions in the output tuser
	localparam int TUSER_OVF = 0;
	localparam int TUSER_ZDV = 1;

	typedef logic [DATA_WIDTH-1:0] word_t;

endpackage

FILE: src/signed_int_divider_core.sv
// ----------------------------------------------------------------------------
// signed_int_divider_core
// Pipelined signed divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
// The core takes one (numerator, denominator) word per cycle and returns one
// quotient word per input word, in order. One stage takes the operand
// magnitudes, DATA_WIDTH restoring shift-subtract stages each resolve one
// quotient bit, and the output register applies the sign. Throughput is one
// word per cycle while the output side accepts; the whole pipeline freezes
// while a finished word waits on m_tready. A zero divisor returns quotient 0
// with zero_divisor set; the most negative value divided by -1 returns the
// largest positive value with overflowed set. No state is kept between words.
module signed_int_divider_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [DATA_WIDTH-1:0] numerator, [2*DATA_WIDTH-1:DATA_WIDTH] denominator
	input  logic [sidiv_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [DATA_WIDTH-1:0] quotient, upper bits zero
	output logic [sidiv_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] overflowed, [1] zero_divisor
	output logic [sidiv_pkg::OUT_TUSER_W-1:0]   m_tuser
);
	import sidiv_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam word_t MIN_NEG = {1'b1, {(DW-1){1'b0}}};
	localparam word_t MAX_POS = {1'b0, {(DW-1){1'b1}}};

	// global advance: pipeline moves when the output slot is free or taken
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ---------------- entry: magnitudes and special cases ----------------
	word_t num, den, num_mag, den_mag;
	logic  num_neg, den_neg;

	assign num     = s_tdata[DW-1:0];
	assign den     = s_tdata[2*DW-1:DW];
	assign num_neg = num[DW-1];
	assign den_neg = den[DW-1];
	assign num_mag = num_neg ? (~num + 1'b1) : num;
	assign den_mag = den_neg ? (~den + 1'b1) : den;

	// stage rows: index 0 is the entry register, index k holds k bits done
	logic  vld_s [0:DW];
	word_t rem_s [0:DW];   // partial remainder
	word_t quo_s [0:DW];   // dividend bits shifting out, quotient bits in
	word_t dvs_s [0:DW];   // divisor magnitude
	logic  neg_s [0:DW];
	logic  ovf_s [0:DW];
	logic  zdv_s [0:DW];

	// ---------------- one quotient bit per stage ----------------
	word_t       rem_nxt [0:DW-1];
	word_t       quo_nxt [0:DW-1];
	logic [DW:0] trial   [0:DW-1];
	logic [DW:0] diff    [0:DW-1];

	always_comb begin
		for (int k = 0; k < DW; k++) begin
			trial[k] = {rem_s[k], quo_s[k][DW-1]};
			diff[k]  = trial[k] - {1'b0, dvs_s[k]};
			if (!diff[k][DW]) begin
				rem_nxt[k] = diff[k][DW-1:0];
				quo_nxt[k] = {quo_s[k][DW-2:0], 1'b1};
			end else begin
				rem_nxt[k] = trial[k][DW-1:0];
				quo_nxt[k] = {quo_s[k][DW-2:0], 1'b0};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DW; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= s_tvalid;
			for (int k = 0; k < DW; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= '0;
			quo_s[0] <= num_mag;
			dvs_s[0] <= den_mag;
			neg_s[0] <= num_neg ^ den_neg;
			zdv_s[0] <= (den == '0);
			ovf_s[0] <= (num == MIN_NEG) && (den == '1);
			for (int k = 0; k < DW; k++) begin
				rem_s[k+1] <= rem_nxt[k];
				quo_s[k+1] <= quo_nxt[k];
				dvs_s[k+1] <= dvs_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				zdv_s[k+1] <= zdv_s[k];
			end
		end
	end

	// ---------------- sign fix and output register ----------------
	word_t quo_fix;

	always_comb begin
		priority if (zdv_s[DW]) begin
			quo_fix = '0;
		end else if (ovf_s[DW]) begin
			quo_fix = MAX_POS;
		end else if (neg_s[DW]) begin
			quo_fix = ~quo_s[DW] + 1'b1;
		end else begin
			quo_fix = quo_s[DW];
		end
	end

	logic  valid_q;
	word_t quo_q;
	logic  ovf_q, zdv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= vld_s[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quo_q <= quo_fix;
			ovf_q <= ovf_s[DW];
			zdv_q <= zdv_s[DW];
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_TDATA_W'(quo_q);
	always_comb begin
		m_tuser            = '0;
		m_tuser[TUSER_OVF] = ovf_q;
		m_tuser[TUSER_ZDV] = zdv_q;
	end

	// ---------------- checks ----------------
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[TUSER_OVF] && m_tuser[TUSER_ZDV]))
		else $error("overflow and zero divisor flagged together");

	a_zdv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[TUSER_ZDV]) |-> (m_tdata[DW-1:0] == '0))
		else $error("zero divisor result not zero");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[TUSER_OVF]) |-> (m_tdata[DW-1:0] == MAX_POS))
		else $error("overflow result not saturated");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output word changed");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the signed truncating divider.
// ----------------------------------------------------------------------------
// Directed corner operands, then several hundred random operand pairs, go in
// through the slave side. Each accepted word is run through a local quotient
// predictor. Each word on the master side is compared against the oldest
// prediction. Both sides idle at random, except for one calm stretch.
module testbench;

	import sidiv_pkg::*;

	localparam int    LATENCY    = DATA_WIDTH + 2;
	localparam int    HANG_LIMIT = 2000;
	localparam int    RAND_WORDS = 780;
	localparam int    IDLE_PCT   = 17;
	localparam int    CALM_FIRST = 350;
	localparam int    CALM_LAST  = 500;
	localparam word_t MOST_NEG   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam word_t MOST_POS   = ~MOST_NEG;
	localparam word_t MINUS_ONE  = '1;

	typedef struct packed {
		word_t num;
		word_t den;
	} operands_t;

	typedef struct packed {
		word_t quotient;
		logic  overflowed;
		logic  zero_divisor;
	} quot_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // numerator, denominator
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // quotient
	logic [OUT_TUSER_W-1:0] m_tuser;   // overflowed, zero_divisor

	operands_t  operand_queue[$];
	quot_word_t quotient_queue[$];
	bit         in_fire;
	int         sent_cnt;
	int         recv_cnt;
	int         quiet_cycles;
	int         fail_cnt;

	signed_int_divider_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Truncating signed division on magnitudes, sign from the xor of signs.
	function automatic quot_word_t divide_trunc(word_t num, word_t den);
		quot_word_t r;
		word_t      mag_n;
		word_t      mag_d;
		word_t      mag_q;
		r = '0;
		if (den == '0) begin
			r.zero_divisor = 1'b1;
		end else if (num == MOST_NEG && den == MINUS_ONE) begin
			r.quotient   = MOST_POS;
			r.overflowed = 1'b1;
		end else begin
			mag_n = num[DATA_WIDTH-1] ? word_t'(~num + 1'b1) : num;
			mag_d = den[DATA_WIDTH-1] ? word_t'(~den + 1'b1) : den;
			mag_q = mag_n / mag_d;
			r.quotient = (num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1]) ?
				word_t'(~mag_q + 1'b1) : mag_q;
		end
		return r;
	endfunction

	function automatic word_t small_signed(int span);
		return word_t'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic word_t pick_corner();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return '0;
			3: return MINUS_ONE;
			4: return word_t'(1);
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic operands_t random_operands();
		operands_t op;
		op.num = word_t'($urandom);
		op.den = word_t'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5: op.den = small_signed(16);
			6: begin
				op.num = pick_corner();
				op.den = $urandom_range(0, 1) ? MINUS_ONE : pick_corner();
			end
			7: begin
				// divisor a shifted copy of the dividend: wide spread of quotient sizes
				op.den = word_t'($signed(op.num) >>> $urandom_range(0, DATA_WIDTH - 1));
				if ($urandom_range(0, 1))
					op.den = ~op.den + 1'b1;
			end
			8: begin
				op.num = small_signed(200);
				op.den = small_signed(20);
			end
			default: begin
				op.den = word_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
				if ($urandom_range(0, 1))
					op.den = ~op.den + 1'b1;
			end
		endcase
		return op;
	endfunction

	// Slave-side driver: next word goes out once the current one is taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (operand_queue.size() != 0 &&
			    ((sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) ||
			     $urandom_range(0, 99) >= IDLE_PCT)) begin
				s_tdata  <= IN_TDATA_W'({operand_queue[0].den, operand_queue[0].num});
				s_tvalid <= 1'b1;
				void'(operand_queue.pop_front());
				sent_cnt <= sent_cnt + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Master-side backpressure.
	always @(negedge clk) begin
		m_tready <= (recv_cnt >= CALM_FIRST && recv_cnt < CALM_LAST) ||
			($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Monitor: predict on input handshakes, check on output handshakes.
	always @(posedge clk) begin
		quot_word_t want;
		bit         out_fire;
		in_fire  = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;
		if (in_fire)
			quotient_queue.push_back(divide_trunc(s_tdata[DATA_WIDTH-1:0],
				s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
		if (out_fire) begin
			recv_cnt <= recv_cnt + 1;
			if (quotient_queue.size() == 0) begin
				$error("unexpected output word: quotient %h tuser %b", m_tdata, m_tuser);
				fail_cnt++;
			end else begin
				want = quotient_queue.pop_front();
				if (m_tdata[DATA_WIDTH-1:0] !== want.quotient) begin
					$error("quotient: expected %h, got %h", want.quotient,
						m_tdata[DATA_WIDTH-1:0]);
					fail_cnt++;
				end
				if (m_tuser[TUSER_OVF] !== want.overflowed) begin
					$error("overflowed: expected %b, got %b", want.overflowed,
						m_tuser[TUSER_OVF]);
					fail_cnt++;
				end
				if (m_tuser[TUSER_ZDV] !== want.zero_divisor) begin
					$error("zero_divisor: expected %b, got %b", want.zero_divisor,
						m_tuser[TUSER_ZDV]);
					fail_cnt++;
				end
			end
		end
		// watchdog on cycles without any handshake
		if (in_fire || out_fire) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		sent_cnt = 0;
		recv_cnt = 0;
		fail_cnt = 0;
		quiet_cycles = 0;
		in_fire  = 1'b0;

		// corner operands: flags, extremes, every sign combination
		operand_queue.push_back('{word_t'(0), word_t'(5)});
		operand_queue.push_back('{word_t'(5), word_t'(0)});
		operand_queue.push_back('{word_t'(0), word_t'(0)});
		operand_queue.push_back('{MOST_NEG, word_t'(0)});
		operand_queue.push_back('{MOST_NEG, MINUS_ONE});
		operand_queue.push_back('{MOST_NEG, word_t'(1)});
		operand_queue.push_back('{MOST_NEG, MOST_NEG});
		operand_queue.push_back('{MOST_NEG, MOST_POS});
		operand_queue.push_back('{MOST_NEG, word_t'(2)});
		operand_queue.push_back('{MOST_POS, MOST_NEG});
		operand_queue.push_back('{MOST_POS, word_t'(1)});
		operand_queue.push_back('{MOST_POS, MINUS_ONE});
		operand_queue.push_back('{MOST_POS, MOST_POS});
		operand_queue.push_back('{MINUS_ONE, MOST_NEG});
		operand_queue.push_back('{MINUS_ONE, MINUS_ONE});
		operand_queue.push_back('{word_t'(1), MOST_POS});
		operand_queue.push_back('{word_t'(7), word_t'(2)});
		operand_queue.push_back('{word_t'(-7), word_t'(2)});
		operand_queue.push_back('{word_t'(7), word_t'(-2)});
		operand_queue.push_back('{word_t'(-7), word_t'(-2)});
		operand_queue.push_back('{word_t'(0), MINUS_ONE});
		operand_queue.push_back('{word_t'(12345), MINUS_ONE});
		for (int i = 0; i < RAND_WORDS; i++)
			operand_queue.push_back(random_operands());

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (operand_queue.size() != 0 || s_tvalid || quotient_queue.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (fail_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
